// File: rtl/spq_pkg.sv
package spq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 8;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths on the stream ports
    localparam int PRIO_W      = 16;
    localparam int PAY_FIELD_W = 8;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  payload;
    } entry_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    input  logic               left_beats,
    input  logic               occupied,
    output spq_pkg::entry_t    entry,
    output logic               beats
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // New entry goes ahead of this cell when it is empty or strictly lower.
    assign beats = !occupied || ($signed(new_entry.prio) > $signed(entry_reg.prio));
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (ctl.pop) begin
            entry_next = right_entry;
        end else if (ctl.insert && left_beats) begin
            entry_next = left_entry;
        end else if (ctl.insert && beats) begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// Channel  Dir  tuser               tdata (lowest bit up)
// s_       in   [0] operation       [15:0] priority_req, [23:16] payload
// m_       out  [1:0] status        [15:0] out_priority, [23:16] out_payload,
//                                   [28:24] occupancy, [31:29] zero
// One request per cycle while the m_ side drains the result: every cell compares against the
// new priority at once and all cells shift together, so an accepted insert or pop lands in the cells at once.
// The result sits in an output register; a new request is taken whenever that
// register is empty or is being drained in the same cycle.
// aresetn (synchronous, active low) clears the entry count and the result valid.
// A stalled m_ side holds the result and backs up s_tready; nothing is dropped.
module sorted_priority_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] priority_req, [23:16] payload
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] out_priority, [23:16] out_payload, [28:24] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);
    import spq_pkg::*;

    logic                   accept;
    op_t                    op;
    entry_t                 new_entry;
    logic [31:0]            pay_in_ext;
    cell_ctl_t              ctl;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   is_empty;
    logic                   is_full;

    entry_t                 cell_entry [QUEUE_DEPTH];
    logic                   cell_beats [QUEUE_DEPTH];
    logic                   cell_occ   [QUEUE_DEPTH];

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [31:0]            m_data_reg;
    logic [31:0]            m_data_next;
    status_t                m_status_reg;
    status_t                m_status_next;

    logic [PAYLOAD_BITS+PAY_FIELD_W-1:0] pay_out_ext;
    logic [CNT_W+OCC_W-1:0]              occ_ext;
    status_t                             status_c;
    logic [PRIO_W-1:0]                   prio_c;
    logic [PAY_FIELD_W-1:0]              pay_c;

    // Take a request while the result register is free or draining.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[0]);

    // Keep only the low payload bits that the queue stores.
    assign pay_in_ext        = {{(32-PAY_FIELD_W){1'b0}}, s_tdata[23:16]};
    assign new_entry.prio    = s_tdata[15:0];
    assign new_entry.payload = pay_in_ext[PAYLOAD_BITS-1:0];

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= CNT_W'(QUEUE_DEPTH));

    // Broadcast the command; a dropped insert or a failed pop moves nothing.
    assign ctl.insert = accept && (op == OP_INSERT) && !is_full;
    assign ctl.pop    = accept && (op == OP_POP) && !is_empty;

    // Row of cells: cell 0 is the head of the queue.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);
        if (i == 0) begin : g_head
            spq_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .left_entry (new_entry),
                .right_entry(cell_entry[(i + 1) % QUEUE_DEPTH]),
                .left_beats (1'b0),
                .occupied   (cell_occ[i]),
                .entry      (cell_entry[i]),
                .beats      (cell_beats[i])
            );
        end else if (i == QUEUE_DEPTH - 1) begin : g_tail
            // Nothing lies behind the tail; hold its own value on a pop.
            spq_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .left_entry (cell_entry[i-1]),
                .right_entry(cell_entry[i]),
                .left_beats (cell_beats[i-1]),
                .occupied   (cell_occ[i]),
                .entry      (cell_entry[i]),
                .beats      (cell_beats[i])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .left_entry (cell_entry[i-1]),
                .right_entry(cell_entry[i+1]),
                .left_beats (cell_beats[i-1]),
                .occupied   (cell_occ[i]),
                .entry      (cell_entry[i]),
                .beats      (cell_beats[i])
            );
        end
    end

    // Next count: advance on a stored insert, drop by one on a served pop.
    always_comb begin
        count_next = count_reg;
        priority if (ctl.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Build the result from the head before it shifts.
    assign pay_out_ext = {{PAY_FIELD_W{1'b0}}, cell_entry[0].payload};
    assign occ_ext     = {{OCC_W{1'b0}}, count_next};

    always_comb begin
        status_c = ST_OK;
        prio_c   = '0;
        pay_c    = '0;
        unique case (op)
            OP_POP: begin
                if (is_empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    prio_c = cell_entry[0].prio;
                    pay_c  = pay_out_ext[PAY_FIELD_W-1:0];
                end
            end
            OP_INSERT: begin
                if (is_full) begin
                    status_c = ST_FULL;
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    // Load a fresh result on accept, otherwise clear valid once it is taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        priority if (accept) begin
            m_valid_next  = 1'b1;
            m_data_next   = {3'b000, occ_ext[OCC_W-1:0], pay_c, prio_c};
            m_status_next = status_c;
        end else if (m_tready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Count never exceeds the number of cells.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Head is never lower than its neighbor once two entries are stored.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> ($signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio)))
        else $error("queue head out of order");

    // A served pop drops the count by exactly one.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    // A full report only ever leaves with a full queue.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_INSERT) && is_full) |=> (m_status_reg == ST_FULL)
            && (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full report with room in the queue");

endmodule
